// ===== hw/rtl/gbs_pkg.sv =====
package gbs_pkg;

    typedef struct packed {
        logic [25:0]        area;
        logic [12:0]        height;
        logic [12:0]        width;
        logic signed [13:0] top;
        logic signed [13:0] left;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AREA,
        ST_RUN,
        ST_DONE
    } gbs_state_t;

    localparam int unsigned CELL_LAT = 6;

endpackage

// ===== hw/rtl/greedy_box_suppression_unit.sv =====
// Greedy non-maximum suppression over a stream of score-sorted boxes.
// Input beat (s_*): s_tdata holds left, top, width, height; s_tlast marks
// the last box of a frame. Output beat (m_*): m_tdata holds keep, box
// number and store overflow; m_tlast echoes the frame end of the box.
// One output beat is produced for every input beat, in order.
// Each kept box sits in one cell of a row of MAX_KEPT cells. A box walks
// the row one cell per cycle; every cell runs a six-stage overlap test
// against its stored box and ORs its verdict into a suppress flag that
// trails the box down the row.
// The verdict is read once the box has walked the whole cell row, after
// the area stage. One box is in flight at a time: a new box is accepted
// only after the verdict on the last one has been formed.
// The next box is accepted while a finished result waits in the output
// register; a stalled receiver holds the block only at result time.
// cfg_we writes iou_threshold (1/256 units) and must be used while idle.
// Reset clears the store, the box counter and the output, holds s_tready
// low, and sets the threshold to 128.
module greedy_box_suppression_unit #(
    parameter int unsigned MAX_KEPT  = 64,
    parameter int unsigned MAX_BOXES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // box_left, box_top, box_width, box_height
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // keep, box_number, store_overflow
    output logic        m_tlast    // frame_done
);

    localparam int unsigned KCW     = $clog2(MAX_KEPT + 1);
    localparam int unsigned BCW     = (MAX_BOXES > 2) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned RUN_CYC = MAX_KEPT + gbs_pkg::CELL_LAT;
    localparam int unsigned RCW     = $clog2(RUN_CYC + 1);

    gbs_pkg::gbs_state_t state_reg, state_next;
    logic [8:0]          thr_reg;
    gbs_pkg::box_t       box_reg, box_next;
    logic                fend_reg, fend_next;
    logic [KCW-1:0]      kept_cnt_reg, kept_cnt_next;
    logic [BCW-1:0]      box_cnt_reg, box_cnt_next;
    logic [RCW-1:0]      run_cnt_reg, run_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    gbs_pkg::box_t       chain [0:MAX_KEPT];
    logic                sup [0:MAX_KEPT];
    logic [MAX_KEPT-1:0] occupied;
    logic [MAX_KEPT-1:0] load;

    logic        in_beat, finish, keep, full, store_en;
    logic [31:0] bc_ext;

    assign chain[0] = box_reg;
    assign sup[0]   = 1'b0;

    for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
        assign occupied[k] = 32'(k) < 32'(kept_cnt_reg);
        assign load[k]     = store_en && (32'(kept_cnt_reg) == 32'(k));
        gbs_cell u_cell (
            .aclk     (aclk),
            .thr      (thr_reg),
            .occupied (occupied[k]),
            .load     (load[k]),
            .load_box (box_reg),
            .box_in   (chain[k]),
            .box_out  (chain[k+1]),
            .sup_in   (sup[k]),
            .sup_out  (sup[k+1])
        );
    end

    assign s_tready = aresetn && (state_reg == gbs_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign finish   = (state_reg == gbs_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    assign keep     = !sup[MAX_KEPT];
    assign full     = (32'(kept_cnt_reg) >= MAX_KEPT);
    assign store_en = finish && keep && !full;
    assign bc_ext   = 32'(box_cnt_reg);

    always_comb begin
        state_next    = state_reg;
        box_next      = box_reg;
        fend_next     = fend_reg;
        kept_cnt_next = kept_cnt_reg;
        box_cnt_next  = box_cnt_reg;
        run_cnt_next  = run_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            gbs_pkg::ST_IDLE: begin
                if (in_beat) begin
                    box_next.left   = s_tdata[13:0];
                    box_next.top    = s_tdata[27:14];
                    box_next.width  = s_tdata[40:28];
                    box_next.height = s_tdata[53:41];
                    fend_next       = s_tlast;
                    state_next      = gbs_pkg::ST_AREA;
                end
            end
            gbs_pkg::ST_AREA: begin
                box_next.area = box_reg.width * box_reg.height;
                run_cnt_next  = '0;
                state_next    = gbs_pkg::ST_RUN;
            end
            gbs_pkg::ST_RUN: begin
                run_cnt_next = run_cnt_reg + 1'b1;
                if (32'(run_cnt_reg) == RUN_CYC) begin
                    state_next = gbs_pkg::ST_DONE;
                end
            end
            gbs_pkg::ST_DONE: begin
                if (finish) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'h0, keep && full, bc_ext[9:0], keep};
                    m_tlast_next  = fend_reg;
                    if (store_en) begin
                        kept_cnt_next = kept_cnt_reg + 1'b1;
                    end
                    if (bc_ext + 32'd1 >= MAX_BOXES) begin
                        box_cnt_next = '0;
                    end else begin
                        box_cnt_next = box_cnt_reg + 1'b1;
                    end
                    if (fend_reg) begin
                        kept_cnt_next = '0;
                        box_cnt_next  = '0;
                    end
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default: state_next = gbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbs_pkg::ST_IDLE;
            thr_reg      <= 9'd128;
            kept_cnt_reg <= '0;
            box_cnt_reg  <= '0;
            run_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            kept_cnt_reg <= kept_cnt_next;
            box_cnt_reg  <= box_cnt_next;
            run_cnt_reg  <= run_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        box_reg     <= box_next;
        fend_reg    <= fend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_ovf_needs_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[11] && !m_tdata[0]))
        else $error("overflow reported on a suppressed box");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(kept_cnt_reg) <= MAX_KEPT)
        else $error("kept count beyond store depth");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && fend_reg) |=> (kept_cnt_reg == '0) && (box_cnt_reg == '0))
        else $error("store not cleared after frame end");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == gbs_pkg::ST_AREA))
        else $error("accepted box skipped area stage");
`endif

endmodule

// ===== hw/rtl/gbs_cell.sv =====
module gbs_cell (
    input  logic          aclk,
    input  logic [8:0]    thr,
    input  logic          occupied,
    input  logic          load,
    input  gbs_pkg::box_t load_box,
    input  gbs_pkg::box_t box_in,
    output gbs_pkg::box_t box_out,
    input  logic          sup_in,
    output logic          sup_out
);

    gbs_pkg::box_t st_reg;
    gbs_pkg::box_t fwd_reg;

    logic signed [14:0] la, lb, ra, rb, ta, tb, ba, bb;
    logic signed [14:0] xlo, xhi, ylo, yhi, xd, yd;
    logic [12:0] ow_next, oh_next;

    logic [12:0] ow_reg, oh_reg;
    logic [26:0] sum1_reg, sum2_reg;
    logic [25:0] inter2_reg, inter3_reg, inter4_reg;
    logic [26:0] uni3_reg;
    logic [35:0] prod4_reg;
    logic        hit_reg;
    logic        sup_reg;

    always_comb begin
        la  = 15'(box_in.left);
        lb  = 15'(st_reg.left);
        ra  = la + $signed({2'b00, box_in.width});
        rb  = lb + $signed({2'b00, st_reg.width});
        ta  = 15'(box_in.top);
        tb  = 15'(st_reg.top);
        ba  = ta + $signed({2'b00, box_in.height});
        bb  = tb + $signed({2'b00, st_reg.height});
        xlo = (la > lb) ? la : lb;
        xhi = (ra < rb) ? ra : rb;
        ylo = (ta > tb) ? ta : tb;
        yhi = (ba < bb) ? ba : bb;
        xd  = xhi - xlo;
        yd  = yhi - ylo;
        ow_next = (xhi > xlo) ? xd[12:0] : 13'd0;
        oh_next = (yhi > ylo) ? yd[12:0] : 13'd0;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            st_reg <= load_box;
        end
        fwd_reg    <= box_in;
        ow_reg     <= ow_next;
        oh_reg     <= oh_next;
        sum1_reg   <= 27'(box_in.area) + 27'(st_reg.area);
        inter2_reg <= ow_reg * oh_reg;
        sum2_reg   <= sum1_reg;
        uni3_reg   <= sum2_reg - 27'(inter2_reg);
        inter3_reg <= inter2_reg;
        prod4_reg  <= 36'(thr) * 36'(uni3_reg);
        inter4_reg <= inter3_reg;
        hit_reg    <= occupied && ({2'b00, inter4_reg, 8'h00} > prod4_reg);
        sup_reg    <= sup_in | hit_reg;
    end

    assign box_out = fwd_reg;
    assign sup_out = sup_reg;

endmodule
